FILE: rtl/pci_pkg.sv
`timescale 1ns / 1ps
package pci_pkg;

  localparam int CELLS      = 1024;
  localparam int CELL_W     = $clog2(CELLS);
  localparam int CNT_W      = CELL_W + 1;
  localparam int COLOR_BITS = 32;
  localparam int PASS_W     = 7;
  localparam int ENT_W      = 1 + PASS_W + COLOR_BITS;
  localparam logic [PASS_W-1:0] PASS_START = '1;

  typedef enum logic [1:0] {
    FN_GUESS  = 2'd0,
    FN_SET    = 2'd1,
    FN_DRAIN  = 2'd2,
    FN_CANCEL = 2'd3
  } func_t;

  typedef struct packed {
    func_t                 func;
    logic [CELL_W-1:0]     cell_id;
    logic [COLOR_BITS-1:0] elim;
  } req_t;

  typedef struct packed {
    logic [CELL_W-1:0]     cell_id;
    logic [COLOR_BITS-1:0] mask;
    logic                  has;
    logic                  done;
    logic                  found;
  } res_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SET_WR,
    ST_GU_RDS,
    ST_GU_RDE,
    ST_GU_CHK,
    ST_DR_RDS,
    ST_DR_RDE,
    ST_DR_CHK,
    ST_CL_RDS,
    ST_CL_WR,
    ST_OUT
  } state_t;

endpackage

FILE: rtl/probe_consequence_intersector.sv
`timescale 1ns / 1ps
// Probe consequence table. Requests enter through a queue-style port: in_func
// and its fields are taken when push is high and full is low. A two-entry
// input queue lets the sender run ahead of the table engine.
// Every request yields exactly one result, read from the out_ ports while
// empty is low and taken with pop. Only drain requests carry data: either one
// surviving consequence (has_consequence) or the end marker (done_res with
// found_any); all other results are all zero.
// The engine works on one request at a time and takes the next only once it is
// back in idle. A guess walks every stacked cell, a drain step scans stack slots
// from the top until it finds a survivor or runs out, and the table reset after
// a final drain or a cancel clears the entry of every stacked cell. These walks
// are paced by the registered memory reads: a stack slot must be read before
// the entry it names can be read.
// After rst_n the engine first marks every table entry invalid; requests
// queue up (full rises after two) but none is processed.
// If the receiver does not pop, the finished result holds in the output
// register, the engine stalls before its next result, and the input queue
// fills and raises full.
module probe_consequence_intersector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_func,
  input  logic [9:0]  in_cell_id,
  input  logic [31:0] in_cell_mask,
  input  logic [31:0] in_keep_mask,
  output logic        empty,
  input  logic        pop,
  output logic [9:0]  out_cell,
  output logic [31:0] out_elim_mask,
  output logic        out_has_consequence,
  output logic        out_done_res,
  output logic        out_found_any
);
  import pci_pkg::*;

  logic req_valid, req_take, out_valid;
  req_t req;
  res_t res;

  pci_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_func(in_func), .in_cell_id(in_cell_id),
    .in_cell_mask(in_cell_mask), .in_keep_mask(in_keep_mask),
    .req_valid(req_valid), .req(req), .req_take(req_take)
  );

  pci_back u_back (
    .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req(req),
    .req_take(req_take), .out_valid(out_valid), .out_res(res),
    .out_pop(pop)
  );

  assign empty               = !out_valid;
  assign out_cell            = 10'(res.cell_id);
  assign out_elim_mask       = 32'(res.mask);
  assign out_has_consequence = res.has;
  assign out_done_res        = res.done;
  assign out_found_any       = res.found;

endmodule

FILE: rtl/pci_ram.sv
`timescale 1ns / 1ps
module pci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/pci_front.sv
`timescale 1ns / 1ps
module pci_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   in_func,
  input  logic [9:0]                   in_cell_id,
  input  logic [31:0]                  in_cell_mask,
  input  logic [31:0]                  in_keep_mask,
  output logic                         req_valid,
  output pci_pkg::req_t                req,
  input  logic                         req_take
);
  import pci_pkg::*;

  req_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;
  req_t       new_req;

  // Eliminated colors are the ones present before the change and absent after it.
  always_comb begin
    new_req.func    = func_t'(in_func);
    new_req.cell_id = CELL_W'(in_cell_id);
    new_req.elim    = COLOR_BITS'(in_cell_mask & ~in_keep_mask);
  end

  assign full      = (cnt_r == 2'd2);
  assign req_valid = (cnt_r != 2'd0);
  assign req       = q_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = req_take && req_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= new_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

FILE: rtl/pci_back.sv
`timescale 1ns / 1ps
module pci_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  input  pci_pkg::req_t req,
  output logic          req_take,
  output logic          out_valid,
  output pci_pkg::res_t out_res,
  input  logic          out_pop
);
  import pci_pkg::*;

  state_t                st_r, st_nxt;
  req_t                  req_r, req_nxt;
  res_t                  res_r, res_nxt;
  res_t                  out_r, out_nxt;
  logic                  out_v_r, out_v_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      dp_r, dp_nxt;
  logic [CNT_W-1:0]      r_r, r_nxt;
  logic [CNT_W-1:0]      w_r, w_nxt;
  logic [PASS_W-1:0]     pn_r, pn_nxt;
  logic                  found_r, found_nxt;
  logic [CELL_W-1:0]     c_r, c_nxt;

  logic                  e_we;
  logic [CELL_W-1:0]     e_waddr, e_raddr;
  logic [ENT_W-1:0]      e_wdata, e_rdata;
  logic                  s_we;
  logic [CELL_W-1:0]     s_waddr, s_wdata, s_raddr, s_rdata;

  logic                  ev;
  logic [PASS_W-1:0]     ep;
  logic [COLOR_BITS-1:0] em, nm;
  logic [CNT_W-1:0]      top_idx;

  pci_ram #(.WIDTH(ENT_W), .DEPTH(CELLS)) u_entry (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  pci_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  assign ev        = e_rdata[ENT_W-1];
  assign ep        = e_rdata[ENT_W-2 -: PASS_W];
  assign em        = e_rdata[COLOR_BITS-1:0];
  assign nm        = em & req_r.elim;
  assign top_idx   = cnt_r - dp_r - CNT_W'(1);
  assign out_valid = out_v_r;
  assign out_res   = out_r;

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
    c_r   <= c_nxt;
    w_r   <= w_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_INIT;
      out_v_r <= 1'b0;
      cnt_r   <= '0;
      dp_r    <= '0;
      r_r     <= '0;
      pn_r    <= PASS_START;
      found_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      out_v_r <= out_v_nxt;
      cnt_r   <= cnt_nxt;
      dp_r    <= dp_nxt;
      r_r     <= r_nxt;
      pn_r    <= pn_nxt;
      found_r <= found_nxt;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    req_nxt   = req_r;
    res_nxt   = res_r;
    out_nxt   = out_r;
    out_v_nxt = out_v_r;
    cnt_nxt   = cnt_r;
    dp_nxt    = dp_r;
    r_nxt     = r_r;
    w_nxt     = w_r;
    pn_nxt    = pn_r;
    found_nxt = found_r;
    c_nxt     = c_r;
    req_take  = 1'b0;
    e_we      = 1'b0;
    e_waddr   = c_r;
    e_wdata   = '0;
    e_raddr   = s_rdata;
    s_we      = 1'b0;
    s_waddr   = w_r[CELL_W-1:0];
    s_wdata   = c_r;
    s_raddr   = r_r[CELL_W-1:0];

    if (out_v_r && out_pop) begin
      out_v_nxt = 1'b0;
    end

    case (st_r)
      // After reset every table entry is marked invalid, one per cycle.
      ST_INIT: begin
        e_we    = 1'b1;
        e_waddr = r_r[CELL_W-1:0];
        e_wdata = '0;
        if (r_r == CNT_W'(CELLS - 1)) begin
          r_nxt  = '0;
          st_nxt = ST_IDLE;
        end else begin
          r_nxt = r_r + CNT_W'(1);
        end
      end

      ST_IDLE: begin
        e_raddr = req.cell_id;
        if (req_valid) begin
          req_take = 1'b1;
          req_nxt  = req;
          res_nxt  = '0;
          r_nxt    = '0;
          w_nxt    = '0;
          c_nxt    = req.cell_id;
          case (req.func)
            FN_SET:    st_nxt = ST_SET_WR;
            FN_GUESS:  st_nxt = ST_GU_RDS;
            FN_DRAIN:  st_nxt = ST_DR_RDS;
            FN_CANCEL: st_nxt = ST_CL_RDS;
            default:   st_nxt = ST_CL_RDS;
          endcase
        end
      end

      ST_SET_WR: begin
        st_nxt  = ST_OUT;
        e_waddr = req_r.cell_id;
        if (!ev) begin
          if (!($signed(pn_r) > $signed(PASS_W'(0))) && cnt_r < CNT_W'(CELLS)) begin
            e_we    = 1'b1;
            e_wdata = {1'b1, pn_r, req_r.elim};
            s_we    = 1'b1;
            s_waddr = cnt_r[CELL_W-1:0];
            s_wdata = req_r.cell_id;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end else if (ep == pn_r) begin
          // A revisit while the pass number is zero widens the entry; in other passes it is a no-op.
          if (pn_r == '0) begin
            e_we    = 1'b1;
            e_wdata = {1'b1, ep, em | req_r.elim};
          end
        end else begin
          e_we    = 1'b1;
          e_wdata = (nm == '0) ? '0 : {1'b1, pn_r, nm};
        end
      end

      ST_GU_RDS: begin
        if (r_r >= cnt_r) begin
          cnt_nxt = w_r;
          dp_nxt  = '0;
          pn_nxt  = pn_r + PASS_W'(1);
          st_nxt  = ST_OUT;
        end else begin
          st_nxt = ST_GU_RDE;
        end
      end

      ST_GU_RDE: begin
        e_raddr = s_rdata;
        c_nxt   = s_rdata;
        st_nxt  = ST_GU_CHK;
      end

      // Survivors are compacted toward the bottom of the stack in their old order.
      ST_GU_CHK: begin
        if (ev && $signed(ep) >= $signed(pn_r)) begin
          s_we  = 1'b1;
          w_nxt = w_r + CNT_W'(1);
        end else begin
          e_we    = 1'b1;
          e_wdata = '0;
        end
        r_nxt  = r_r + CNT_W'(1);
        st_nxt = ST_GU_RDS;
      end

      ST_DR_RDS: begin
        s_raddr = top_idx[CELL_W-1:0];
        if (dp_r >= cnt_r) begin
          res_nxt.done  = 1'b1;
          res_nxt.found = found_r;
          r_nxt         = '0;
          st_nxt        = ST_CL_RDS;
        end else begin
          st_nxt = ST_DR_RDE;
        end
      end

      ST_DR_RDE: begin
        e_raddr = s_rdata;
        c_nxt   = s_rdata;
        st_nxt  = ST_DR_CHK;
      end

      ST_DR_CHK: begin
        dp_nxt = dp_r + CNT_W'(1);
        if (ev && ep == pn_r) begin
          e_we            = 1'b1;
          e_wdata         = '0;
          found_nxt       = 1'b1;
          res_nxt.cell_id = c_r;
          res_nxt.mask    = em;
          res_nxt.has     = 1'b1;
          st_nxt          = ST_OUT;
        end else begin
          st_nxt = ST_DR_RDS;
        end
      end

      ST_CL_RDS: begin
        if (r_r >= cnt_r) begin
          cnt_nxt   = '0;
          dp_nxt    = '0;
          pn_nxt    = PASS_START;
          found_nxt = 1'b0;
          st_nxt    = ST_OUT;
        end else begin
          st_nxt = ST_CL_WR;
        end
      end

      ST_CL_WR: begin
        e_we    = 1'b1;
        e_waddr = s_rdata;
        e_wdata = '0;
        r_nxt   = r_r + CNT_W'(1);
        st_nxt  = ST_CL_RDS;
      end

      ST_OUT: begin
        if (!out_v_r || out_pop) begin
          out_nxt   = res_r;
          out_v_nxt = 1'b1;
          st_nxt    = ST_IDLE;
        end
      end

      default: st_nxt = ST_IDLE;
    endcase
  end

endmodule
